### rtl/core/hsrb_pkg.sv
// ----------------------------------------------------------------------------
// hsrb_pkg
// Shared types, codes and hash constants for the hashed shard ring buffers.
// ----------------------------------------------------------------------------
package hsrb_pkg;

    localparam int SHARD_COUNT     = 15;
    localparam int SHARD_W         = 4;
    localparam int DEFAULT_SHARD   = 14;
    localparam int DEF_RING_DEPTH  = 256;
    localparam int HASH_MOD        = 71;
    localparam int RESIDUE_W       = 7;
    localparam int BYTE_SUM_W      = 16;
    localparam int QUOT_W          = 10;
    localparam int RECIP_SHIFT     = 22;
    localparam logic [31:0] RECIP_MUL = 32'd59075;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = 2;
    localparam int QCNT_W          = 3;

    // mode codes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_PUSHED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_POPPED  = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // 256^k mod 71 for the eight bytes of the mixed word
    localparam logic [5:0] BYTE_WEIGHT [8] = '{6'd1, 6'd43, 6'd3, 6'd58,
                                               6'd9, 6'd32, 6'd27, 6'd25};

    localparam logic [6:0] SHARD_PRIMES [SHARD_COUNT] = '{
        7'd2, 7'd3, 7'd5, 7'd7, 7'd11, 7'd13, 7'd17, 7'd19,
        7'd23, 7'd29, 7'd31, 7'd41, 7'd47, 7'd59, 7'd71};

    typedef logic [SHARD_W-1:0] t_shard_lut [HASH_MOD];

    // residue to shard: first prime that divides the residue, else DEFAULT_SHARD
    function automatic t_shard_lut f_build_lut();
        t_shard_lut lut;
        logic       found;
        for (int r = 0; r < HASH_MOD; r++) begin
            found  = 1'b0;
            lut[r] = SHARD_W'(DEFAULT_SHARD);
            for (int i = 0; i < SHARD_COUNT; i++) begin
                if (!found && ((r % SHARD_PRIMES[i]) == 0)) begin
                    lut[r] = SHARD_W'(i);
                    found  = 1'b1;
                end
            end
        end
        return lut;
    endfunction

    localparam t_shard_lut SHARD_LUT = f_build_lut();

    typedef struct packed {
        logic [22:0] process_id;
        logic [63:0] timestamp;
        logic [63:0] instr_pointer;
        logic [63:0] stack_pointer;
        logic [63:0] reg_a;
        logic [63:0] reg_b;
        logic [63:0] reg_c;
        logic [63:0] reg_d;
        logic [63:0] mem_bytes;
        logic [63:0] cpu_ticks;
    } t_sample;

    typedef struct packed {
        logic               mode;
        logic [SHARD_W-1:0] shard;
        t_sample            sample;
    } t_work;

endpackage

### rtl/core/hsrb_front.sv
// ----------------------------------------------------------------------------
// hsrb_front
// Accepts items, hashes each sample to a shard and hands items to the queue.
// ----------------------------------------------------------------------------
module hsrb_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic                       i_mode,
    input  hsrb_pkg::t_sample          i_sample,
    input  logic [hsrb_pkg::QCNT_W-1:0] i_q_count,
    output logic                       o_q_wr,
    output hsrb_pkg::t_work            o_q_data
);
    import hsrb_pkg::*;

    logic                  w_accept;
    logic [QCNT_W:0]       w_credit;
    logic [63:0]           w_mixed;
    logic [BYTE_SUM_W-1:0] w_sum;
    logic [31:0]           w_prod;
    logic [BYTE_SUM_W-1:0] w_qmul;
    logic [RESIDUE_W-1:0]  w_residue;

    logic                  r1_valid;
    t_work                 r1_work;
    logic [BYTE_SUM_W-1:0] r1_sum;
    logic                  r2_valid;
    t_work                 r2_work;
    logic [BYTE_SUM_W-1:0] r2_sum;
    logic [QUOT_W-1:0]     r2_quot;

    // reserve queue room for everything still in the hash stages
    assign w_credit = (QCNT_W+1)'(i_q_count) + (QCNT_W+1)'(r1_valid)
                    + (QCNT_W+1)'(r2_valid);
    assign o_full   = (w_credit >= (QCNT_W+1)'(QUEUE_DEPTH));
    assign w_accept = i_push && !o_full;

    assign w_mixed = i_sample.instr_pointer ^ i_sample.stack_pointer ^ i_sample.reg_a
                   ^ i_sample.mem_bytes ^ i_sample.cpu_ticks;

    // byte-weighted sum keeps the value congruent mod 71
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < 8; k++) begin
            w_sum = w_sum + BYTE_SUM_W'(w_mixed[8*k +: 8]) * BYTE_SUM_W'(BYTE_WEIGHT[k]);
        end
    end

    assign w_prod    = 32'(r1_sum) * RECIP_MUL;
    assign w_qmul    = BYTE_SUM_W'(r2_quot) * BYTE_SUM_W'(HASH_MOD);
    assign w_residue = RESIDUE_W'(r2_sum - w_qmul);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= w_accept;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_work.mode   <= i_mode;
        r1_work.shard  <= '0;
        r1_work.sample <= i_sample;
        r1_sum         <= w_sum;
        r2_work        <= r1_work;
        r2_sum         <= r1_sum;
        r2_quot        <= w_prod[RECIP_SHIFT +: QUOT_W];
    end

    always_comb begin
        o_q_data       = r2_work;
        o_q_data.shard = SHARD_LUT[w_residue];
    end
    assign o_q_wr = r2_valid;

endmodule

### rtl/core/hsrb_queue.sv
// ----------------------------------------------------------------------------
// hsrb_queue
// Short queue between the hash front and the ring back.
// ----------------------------------------------------------------------------
module hsrb_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  hsrb_pkg::t_work             i_wr_data,
    input  logic                        i_rd,
    output hsrb_pkg::t_work             o_rd_data,
    output logic                        o_valid,
    output logic [hsrb_pkg::QCNT_W-1:0] o_count
);
    import hsrb_pkg::*;

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({i_wr, i_rd})
                2'b10: begin
                    r_count <= r_count + QCNT_W'(1);
                end
                2'b01: begin
                    r_count <= r_count - QCNT_W'(1);
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_valid   = (r_count != '0);
    assign o_count   = r_count;

endmodule

### rtl/core/hsrb_back.sv
// ----------------------------------------------------------------------------
// hsrb_back
// Ring pointers, sample store and the result register.
// ----------------------------------------------------------------------------
module hsrb_back #(
    parameter int RING_DEPTH = hsrb_pkg::DEF_RING_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  hsrb_pkg::t_work              i_q_data,
    output logic                         o_q_rd,
    output logic                         o_valid,
    input  logic                         i_pop,
    output logic [1:0]                   o_status,
    output logic [hsrb_pkg::SHARD_W-1:0] o_shard,
    output hsrb_pkg::t_sample            o_sample
);
    import hsrb_pkg::*;

    localparam int SLOT_W    = $clog2(RING_DEPTH);
    localparam int FILL_W    = $clog2(RING_DEPTH + 1);
    localparam int MEM_DEPTH = SHARD_COUNT * RING_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    logic [SLOT_W-1:0] r_head [SHARD_COUNT];
    logic [SLOT_W-1:0] r_tail [SHARD_COUNT];
    logic [FILL_W-1:0] r_fill [SHARD_COUNT];
    t_sample           r_store [MEM_DEPTH];
    t_sample           r_rd_data;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [SHARD_W-1:0] r_shard;
    logic              r_has_data;

    logic               w_take;
    logic               w_is_push;
    logic               w_any;
    logic [SHARD_W-1:0] w_pop_shard;
    logic [SHARD_W-1:0] w_sel;
    logic [SLOT_W-1:0]  w_slot;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_ring_full;

    function automatic logic [SLOT_W-1:0] f_next(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    assign w_take    = i_q_valid && (!r_out_valid || i_pop);
    assign w_is_push = (i_q_data.mode == MODE_PUSH);

    // lowest-numbered ring that holds a sample
    always_comb begin
        w_any       = 1'b0;
        w_pop_shard = '0;
        for (int k = SHARD_COUNT - 1; k >= 0; k--) begin
            if (r_fill[k] != '0) begin
                w_any       = 1'b1;
                w_pop_shard = SHARD_W'(k);
            end
        end
    end

    assign w_sel       = w_is_push ? i_q_data.shard : w_pop_shard;
    assign w_slot      = w_is_push ? r_head[w_sel] : r_tail[w_sel];
    assign w_addr      = ADDR_W'(w_sel) * ADDR_W'(RING_DEPTH) + ADDR_W'(w_slot);
    assign w_ring_full = (r_fill[w_sel] == FILL_W'(RING_DEPTH));

    always_ff @(posedge i_clk) begin
        if (w_take && w_is_push) begin
            r_store[w_addr] <= i_q_data.sample;
        end
        if (w_take && !w_is_push && w_any) begin
            r_rd_data <= r_store[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SHARD_COUNT; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_fill[k] <= '0;
            end
            r_out_valid <= 1'b0;
            r_status    <= ST_PUSHED;
            r_shard     <= '0;
            r_has_data  <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                if (w_is_push) begin
                    r_head[w_sel] <= f_next(r_head[w_sel]);
                    r_shard       <= w_sel;
                    r_has_data    <= 1'b0;
                    if (w_ring_full) begin
                        // oldest entry is overwritten
                        r_tail[w_sel] <= f_next(r_tail[w_sel]);
                        r_status      <= ST_DROPPED;
                    end else begin
                        r_fill[w_sel] <= r_fill[w_sel] + FILL_W'(1);
                        r_status      <= ST_PUSHED;
                    end
                end else if (w_any) begin
                    r_tail[w_sel] <= f_next(r_tail[w_sel]);
                    r_fill[w_sel] <= r_fill[w_sel] - FILL_W'(1);
                    r_status      <= ST_POPPED;
                    r_shard       <= w_sel;
                    r_has_data    <= 1'b1;
                end else begin
                    r_status   <= ST_EMPTY;
                    r_shard    <= '0;
                    r_has_data <= 1'b0;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_q_rd   = w_take;
    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_shard  = r_shard;
    assign o_sample = r_has_data ? r_rd_data : '0;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |-> !w_take)
        else $error("work taken while result still held");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_is_push && w_any) |=>
        (r_out_valid && r_has_data && r_status == ST_POPPED))
        else $error("pop from non-empty ring gave no sample");

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_is_push) |=>
        (r_out_valid && !r_has_data && (r_status == ST_PUSHED || r_status == ST_DROPPED)))
        else $error("push result malformed");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_is_push && !w_any) |=>
        (r_status == ST_EMPTY && r_shard == '0 && !r_has_data))
        else $error("empty pop result malformed");

endmodule

### rtl/core/hashed_shard_ring_buffers.sv
// ----------------------------------------------------------------------------
// hashed_shard_ring_buffers
// Hashes process samples into 15 rings and drains them lowest ring first.
// ----------------------------------------------------------------------------
//  channel   | ports                                  | transfer when
//  ----------+----------------------------------------+--------------------
//  input     | push, full, i_mode .. i_cpu_ticks      | push && !full
//  result    | empty, pop, o_status .. o_out_cpu_ticks| pop && !empty
//
//  one item per cycle sustained while results are popped as they show;
//  push and pop results pass 2 hash stages, queue write, result register
//  the rate is set by the single-port ring store: one read or one write a cycle
//  reset is synchronous, active low; it clears ring pointers and fill counts
//  a held result stops new items once the queue and hash stages hold 4 items
// ----------------------------------------------------------------------------
module hashed_shard_ring_buffers #(
    parameter int RING_DEPTH = hsrb_pkg::DEF_RING_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [22:0] i_process_id,
    input  logic [63:0] i_timestamp,
    input  logic [63:0] i_instr_pointer,
    input  logic [63:0] i_stack_pointer,
    input  logic [63:0] i_reg_a,
    input  logic [63:0] i_reg_b,
    input  logic [63:0] i_reg_c,
    input  logic [63:0] i_reg_d,
    input  logic [63:0] i_mem_bytes,
    input  logic [63:0] i_cpu_ticks,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [3:0]  o_shard,
    output logic [22:0] o_out_process_id,
    output logic [63:0] o_out_timestamp,
    output logic [63:0] o_out_instr_pointer,
    output logic [63:0] o_out_stack_pointer,
    output logic [63:0] o_out_reg_a,
    output logic [63:0] o_out_reg_b,
    output logic [63:0] o_out_reg_c,
    output logic [63:0] o_out_reg_d,
    output logic [63:0] o_out_mem_bytes,
    output logic [63:0] o_out_cpu_ticks
);
    import hsrb_pkg::*;

    t_sample           w_in_sample;
    t_sample           w_out_sample;
    t_work             w_fq_data;
    t_work             w_qb_data;
    logic              w_fq_wr;
    logic              w_qb_valid;
    logic              w_qb_rd;
    logic [QCNT_W-1:0] w_q_count;
    logic              w_out_valid;

    assign w_in_sample.process_id    = i_process_id;
    assign w_in_sample.timestamp     = i_timestamp;
    assign w_in_sample.instr_pointer = i_instr_pointer;
    assign w_in_sample.stack_pointer = i_stack_pointer;
    assign w_in_sample.reg_a         = i_reg_a;
    assign w_in_sample.reg_b         = i_reg_b;
    assign w_in_sample.reg_c         = i_reg_c;
    assign w_in_sample.reg_d         = i_reg_d;
    assign w_in_sample.mem_bytes     = i_mem_bytes;
    assign w_in_sample.cpu_ticks     = i_cpu_ticks;

    hsrb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_mode    (i_mode),
        .i_sample  (w_in_sample),
        .i_q_count (w_q_count),
        .o_q_wr    (w_fq_wr),
        .o_q_data  (w_fq_data)
    );

    hsrb_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_fq_wr),
        .i_wr_data (w_fq_data),
        .i_rd      (w_qb_rd),
        .o_rd_data (w_qb_data),
        .o_valid   (w_qb_valid),
        .o_count   (w_q_count)
    );

    hsrb_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qb_valid),
        .i_q_data  (w_qb_data),
        .o_q_rd    (w_qb_rd),
        .o_valid   (w_out_valid),
        .i_pop     (pop),
        .o_status  (o_status),
        .o_shard   (o_shard),
        .o_sample  (w_out_sample)
    );

    assign empty               = !w_out_valid;
    assign o_out_process_id    = w_out_sample.process_id;
    assign o_out_timestamp     = w_out_sample.timestamp;
    assign o_out_instr_pointer = w_out_sample.instr_pointer;
    assign o_out_stack_pointer = w_out_sample.stack_pointer;
    assign o_out_reg_a         = w_out_sample.reg_a;
    assign o_out_reg_b         = w_out_sample.reg_b;
    assign o_out_reg_c         = w_out_sample.reg_c;
    assign o_out_reg_d         = w_out_sample.reg_d;
    assign o_out_mem_bytes     = w_out_sample.mem_bytes;
    assign o_out_cpu_ticks     = w_out_sample.cpu_ticks;

endmodule
